### hdl/spq_pkg.sv
// ============================================================================
// spq_pkg: shared types and codes for the sorted priority queue
// Entry layout, sort key, operation and status codes, controller states.
// ============================================================================
package spq_pkg;

    localparam int ENTRY_W = 51;
    localparam int KEY_W   = 35;
    localparam int OCC_W   = 5;

    typedef struct packed {
        logic [7:0]  importance;
        logic [15:0] date;
        logic [10:0] minutes;
        logic [15:0] id;
    } entry_t;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_TAKE,
        S_FIN
    } state_t;

    // Higher importance, then later date, then later time.
    function automatic key_t entry_key(input entry_t e);
        entry_key = {e.importance, e.date, e.minutes};
    endfunction

endpackage

### hdl/sorted_priority_queue_core.sv
// ============================================================================
// sorted_priority_queue_core: memory-based sorted priority queue
// Keeps up to DEPTH entries best first in one synchronous RAM.
// ============================================================================
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat:
//   insert an entry, pop the head, or remove the first entry with a given id.
//   Output channel (out_valid / out_stall) returns exactly one result beat per
//   operation: status, the popped or removed entry (zero otherwise) and the
//   occupancy after the operation.
//   The block works on one operation at a time. in_stall is high from the
//   accepting edge until the result has been loaded into the output register.
//   Every operation walks the entry RAM one entry per cycle through its single
//   read and single write port; operations that touch no entry (full, empty,
//   unused code) go from accept straight to the completion state.
//   A result waiting in the output register does not block the next accept;
//   only the following result waits for the register to drain.
//   Reset empties the queue at once (count cleared); the RAM is not cleared,
//   entries beyond the count are never read.
// ============================================================================
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // operation channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  new_importance,
    input  logic [15:0] new_date,
    input  logic [10:0] new_minutes,
    input  logic [15:0] new_id,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  out_importance,
    output logic [15:0] out_date,
    output logic [10:0] out_minutes,
    output logic [15:0] out_id,
    output logic [4:0]  occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Entry RAM: one write port, one registered read port
    // ------------------------------------------------------------------
    entry_t          mem [DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    entry_t          mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra;
    entry_t          rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // Control and working registers
    // ------------------------------------------------------------------
    state_t          state_reg,   state_next;
    logic [CW-1:0]   count_reg,   count_next;
    logic [AW-1:0]   idx_reg,     idx_next;     // write slot (insert) / read slot (take)
    logic            have_reg,    have_next;    // rd_data_reg holds the entry in flight
    logic            found_reg,   found_next;
    logic            is_pop_reg,  is_pop_next;
    entry_t          item_reg,    item_next;
    status_t         res_stat_reg, res_stat_next;
    entry_t          res_ent_reg, res_ent_next;

    logic            out_valid_reg;
    status_t         out_stat_reg;
    entry_t          out_ent_reg;
    logic [OCC_W-1:0] out_occ_reg;

    logic            in_fire;
    logic            slot_free;
    logic            is_full;
    logic            is_empty;
    logic            ins_stop;
    logic            ins_done;
    logic            take_more;
    logic            take_match;
    logic            take_done;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // Insert walks from the tail toward the head; stop at the first entry
    // that strictly beats the new key (ties go behind the new entry).
    assign ins_stop  = have_reg && (entry_key(rd_data_reg) > entry_key(item_reg));
    assign ins_done  = (idx_reg == '0) || ins_stop;

    // Take walks from the head: find the match, then pull the rest up.
    assign take_more  = ((CW'(idx_reg) + CW'(1)) < count_reg);
    assign take_match = !found_reg && (is_pop_reg || (rd_data_reg.id == item_reg.id));
    assign take_done  = have_reg && !take_more;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (func_t'(func))
                        FUNC_INSERT: state_next = is_full  ? S_FIN : S_INS;
                        FUNC_POP:    state_next = is_empty ? S_FIN : S_TAKE;
                        FUNC_REMOVE: state_next = is_empty ? S_FIN : S_TAKE;
                        default:     state_next = S_FIN;
                    endcase
                end
            end
            S_INS:
            begin
                if (ins_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_TAKE:
            begin
                if (take_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we        = 1'b0;
        mem_wa        = idx_reg;
        mem_wd        = rd_data_reg;
        mem_re        = 1'b0;
        mem_ra        = idx_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        have_next     = have_reg;
        found_next    = found_reg;
        is_pop_next   = is_pop_reg;
        item_next     = item_reg;
        res_stat_next = res_stat_reg;
        res_ent_next  = res_ent_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    item_next     = '{importance: new_importance, date: new_date,
                                      minutes: new_minutes, id: new_id};
                    is_pop_next   = (func_t'(func) == FUNC_POP);
                    res_ent_next  = '0;
                    have_next     = 1'b0;
                    found_next    = 1'b0;
                    idx_next      = '0;
                    res_stat_next = STAT_OK;
                    unique case (func_t'(func))
                        FUNC_INSERT:
                        begin
                            // start at the free slot after the tail
                            idx_next = AW'(count_reg);
                            if (is_full)
                            begin
                                res_stat_next = STAT_FULL;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (is_empty)
                            begin
                                res_stat_next = STAT_EMPTY;
                            end
                        end
                        FUNC_REMOVE: res_stat_next = STAT_NOTFOUND;
                        default:     res_stat_next = STAT_OK;
                    endcase
                end
            end
            S_INS:
            begin
                priority if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = '0;
                    mem_wd     = item_reg;
                    count_next = count_reg + CW'(1);
                end
                else if (!have_reg)
                begin
                    mem_re    = 1'b1;
                    mem_ra    = idx_reg - AW'(1);
                    have_next = 1'b1;
                end
                else if (ins_stop)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = idx_reg;
                    mem_wd     = item_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    // shift the compared entry one slot toward the tail
                    mem_we   = 1'b1;
                    mem_wa   = idx_reg;
                    mem_wd   = rd_data_reg;
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg != AW'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_ra    = idx_reg - AW'(2);
                        have_next = 1'b1;
                    end
                    else
                    begin
                        have_next = 1'b0;
                    end
                end
            end
            S_TAKE:
            begin
                if (!have_reg)
                begin
                    mem_re    = 1'b1;
                    mem_ra    = idx_reg;
                    have_next = 1'b1;
                end
                else
                begin
                    if (take_match)
                    begin
                        found_next    = 1'b1;
                        res_ent_next  = rd_data_reg;
                        res_stat_next = STAT_OK;
                    end
                    if (found_reg)
                    begin
                        // close the gap: move this entry one slot toward the head
                        mem_we = 1'b1;
                        mem_wa = idx_reg - AW'(1);
                        mem_wd = rd_data_reg;
                    end
                    if (take_more)
                    begin
                        mem_re   = 1'b1;
                        mem_ra   = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                    else if (found_reg || take_match)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_FIN:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            have_reg   <= 1'b0;
            found_reg  <= 1'b0;
            is_pop_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            have_reg   <= have_next;
            found_reg  <= found_next;
            is_pop_reg <= is_pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        item_reg     <= item_next;
        res_stat_reg <= res_stat_next;
        res_ent_reg  <= res_ent_next;
    end

    // ------------------------------------------------------------------
    // Output register: load on completion, drop once the beat is taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FIN) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && slot_free)
        begin
            out_stat_reg <= res_stat_reg;
            out_ent_reg  <= res_ent_reg;
            out_occ_reg  <= OCC_W'(count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_stat_reg;
    assign out_importance = out_ent_reg.importance;
    assign out_date       = out_ent_reg.date;
    assign out_minutes    = out_ent_reg.minutes;
    assign out_id         = out_ent_reg.id;
    assign occupancy      = out_occ_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_no_ram_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("RAM read and write hit the same entry");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside completion");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg == STAT_FULL)) |-> (out_occ_reg == OCC_W'(DEPTH)))
        else $error("full status with queue not full");

endmodule

### tb/sv/sorted_priority_queue_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// sorted_priority_queue_core_test: self-checking bench for the sorted queue
// Drives insert, pop and remove-by-id beats with random gaps and output
// stalls. A shadow queue predicts each result, and every result beat is
// compared field by field with the oldest prediction.
// ============================================================================
module sorted_priority_queue_core_test;
    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 370;
    localparam int HOLD_ITEMS     = 30;

    // Operation code the block does not define; must leave the queue alone.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        status_t    status;
        entry_t     entry;
        logic [4:0] occupancy;
    } queue_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_INSERT;
    logic [7:0]  new_importance = '0;
    logic [15:0] new_date = '0;
    logic [10:0] new_minutes = '0;
    logic [15:0] new_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [7:0]  out_importance;
    logic [15:0] out_date;
    logic [10:0] out_minutes;
    logic [15:0] out_id;
    logic [4:0]  occupancy;

    // Shadow copy of the queue contents, best entry at index 0.
    entry_t         shadow_entries [DEPTH];
    int             shadow_count = 0;
    // Predicted results, oldest first, one per accepted operation beat.
    queue_outcome_t pending_outcomes [$];

    int mismatches   = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    sorted_priority_queue_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .new_importance (new_importance),
        .new_date       (new_date),
        .new_minutes    (new_minutes),
        .new_id         (new_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_importance (out_importance),
        .out_date       (out_date),
        .out_minutes    (out_minutes),
        .out_id         (out_id),
        .occupancy      (occupancy)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow queue
    // ------------------------------------------------------------------------

    // True when a must be served before b: importance, then date, then time.
    function automatic bit outranks(input entry_t a, input entry_t b);
        if (a.importance != b.importance)
            return a.importance > b.importance;
        if (a.date != b.date)
            return a.date > b.date;
        return a.minutes > b.minutes;
    endfunction

    // Pull one entry out of the shadow queue and close the gap behind it.
    function automatic entry_t take_entry(input int pos);
        entry_t got;
        got = shadow_entries[pos];
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        shadow_count--;
        return got;
    endfunction

    // Apply one operation to the shadow queue and return the result it gives.
    function automatic queue_outcome_t predict_queue_op(input logic [1:0] op,
                                                        input entry_t item);
        queue_outcome_t res;
        int pos;
        res.status = STAT_OK;
        res.entry  = '0;
        case (op)
            FUNC_INSERT:
                if (shadow_count >= DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    // Skip only entries strictly better: a tie goes in ahead.
                    pos = 0;
                    while (pos < shadow_count && outranks(shadow_entries[pos], item))
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[pos] = item;
                    shadow_count++;
                end
            FUNC_POP:
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else
                    res.entry = take_entry(0);
            FUNC_REMOVE:
            begin
                // First match counted from the head, the head included.
                res.status = STAT_NOTFOUND;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_entries[i].id == item.id)
                    begin
                        res.entry  = take_entry(i);
                        res.status = STAT_OK;
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        res.occupancy = shadow_count[4:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: both channels are sampled at the rising edge, before any
    // register update of that edge lands. Check the result beat first, since
    // it always belongs to an operation accepted earlier.
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        queue_outcome_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result beat with no operation pending, actual status %0d",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("status",     16'(want.status),           16'(status));
                    compare_field("importance", 16'(want.entry.importance), 16'(out_importance));
                    compare_field("date",       want.entry.date,            out_date);
                    compare_field("minutes",    16'(want.entry.minutes),    16'(out_minutes));
                    compare_field("id",         want.entry.id,              out_id);
                    compare_field("occupancy",  16'(want.occupancy),        16'(occupancy));
                end
            end
            if (in_valid && !in_stall)
                pending_outcomes.push_back(predict_queue_op(func,
                    {new_importance, new_date, new_minutes, new_id}));
        end
    end

    // Give up when neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: hold for a requested stretch, else stall at random.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    function automatic entry_t make_entry(input logic [7:0] importance,
                                          input logic [15:0] date,
                                          input logic [10:0] minutes,
                                          input logic [15:0] id);
        entry_t e;
        e.importance = importance;
        e.date       = date;
        e.minutes    = minutes;
        e.id         = id;
        return e;
    endfunction

    // A third of the entries use only extreme values, so equal keys are common.
    // Minutes run past 1439 now and then: the block compares them as given.
    function automatic entry_t random_entry();
        entry_t e;
        if ($urandom_range(0, 2) == 0)
        begin
            e.importance = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            e.date       = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            e.minutes    = $urandom_range(0, 1) ? 11'd1439 : 11'd0;
        end
        else
        begin
            e.importance = 8'($urandom_range(0, 255));
            e.date       = 16'($urandom_range(0, 65535));
            e.minutes    = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(1440, 2047))
                                                       : 11'($urandom_range(0, 1439));
        end
        // Small ids collide often and exercise first-match removal.
        e.id = $urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                    : 16'($urandom_range(0, 65535));
        return e;
    endfunction

    // Offer one beat, after random idle cycles, and hold it until accepted.
    task automatic send_op(input logic [1:0] op, input entry_t item);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        func           <= op;
        new_importance <= item.importance;
        new_date       <= item.date;
        new_minutes    <= item.minutes;
        new_id         <= item.id;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic await_all_results();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty-queue cases, field extremes, tie order, head and middle removal,
    // unknown id, the unused code, and insert into a full queue.
    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        send_op(FUNC_POP,    random_entry());
        send_op(FUNC_REMOVE, make_entry(8'd0, 16'd0, 11'd0, 16'd5));
        send_op(FUNC_UNUSED, make_entry(8'hFF, 16'hFFFF, 11'h7FF, 16'hFFFF));
        send_op(FUNC_INSERT, make_entry(8'hFF, 16'hFFFF, 11'h7FF, 16'hFFFF));
        send_op(FUNC_INSERT, make_entry(8'd0, 16'd0, 11'd0, 16'd0));
        // Equal keys: id 2 must end up ahead of id 1.
        send_op(FUNC_INSERT, make_entry(8'd100, 16'd500, 11'd600, 16'd1));
        send_op(FUNC_INSERT, make_entry(8'd100, 16'd500, 11'd600, 16'd2));
        send_op(FUNC_INSERT, make_entry(8'd100, 16'd500, 11'd601, 16'd3));
        send_op(FUNC_INSERT, make_entry(8'd100, 16'd501, 11'd0, 16'd4));
        send_op(FUNC_INSERT, make_entry(8'd101, 16'd0, 11'd0, 16'd5));
        send_op(FUNC_REMOVE, make_entry(8'd0, 16'd0, 11'd0, 16'hFFFF));
        send_op(FUNC_REMOVE, make_entry(8'd0, 16'd0, 11'd0, 16'd1));
        send_op(FUNC_REMOVE, make_entry(8'd0, 16'd0, 11'd0, 16'd9999));
        send_op(FUNC_UNUSED, random_entry());
        // Fill up to capacity, then one more insert must be dropped.
        for (int i = 0; i < DEPTH - 5; i++)
            send_op(FUNC_INSERT, make_entry(8'(i * 23), 16'(i * 5000),
                                            11'(1439 - i), 16'(100 + i)));
        send_op(FUNC_INSERT, make_entry(8'hFF, 16'hFFFF, 11'd1439, 16'd77));
        send_op(FUNC_POP, random_entry());
        send_op(FUNC_POP, random_entry());
        await_all_results();
    endtask

    // Random mix that swings the queue between empty and full: bias toward
    // inserts while filling, toward pops and removes while draining.
    task automatic test_random_mix(input int items, input int send_idle,
                                   input int recv_stall);
        int         roll;
        int         insert_share;
        bit         filling;
        logic [1:0] op;
        entry_t     item;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        filling   = 1'b1;
        for (int n = 0; n < items; n++)
        begin
            if (shadow_count >= DEPTH)
                filling = 1'b0;
            else if (shadow_count == 0)
                filling = 1'b1;
            insert_share = filling ? 65 : 30;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = FUNC_UNUSED;
            else if (roll < 3 + insert_share)
                op = FUNC_INSERT;
            else if (roll < 3 + insert_share + (97 - insert_share) / 2)
                op = FUNC_POP;
            else
                op = FUNC_REMOVE;
            item = random_entry();
            // Mostly remove an id that is present, at any position.
            if (op == FUNC_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
                item.id = shadow_entries[$urandom_range(0, shadow_count - 1)].id;
            send_op(op, item);
        end
        await_all_results();
    endtask

    // Hold the result side for a long stretch while beats keep coming, so
    // the block backs up and stalls its input.
    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = LONG_HOLD;
        for (int n = 0; n < HOLD_ITEMS; n++)
            send_op(($urandom_range(0, 3) == 0) ? FUNC_POP : FUNC_INSERT, random_entry());
        await_all_results();
    endtask

    initial
    begin
        foreach (shadow_entries[k])
            shadow_entries[k] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_mix(PHASE_ITEMS, 0, 0);
        test_random_mix(PHASE_ITEMS, 51, 0);
        test_random_mix(PHASE_ITEMS, 0, 51);
        test_output_hold();
        test_random_mix(PHASE_ITEMS, 9, 9);

        // Let any stray result beat show up before the verdict.
        await_all_results();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
hdl/spq_pkg.sv
hdl/sorted_priority_queue_core.sv
tb/sv/sorted_priority_queue_core_test.sv
